FILE: sv/qwt_pkg.sv
// ----------------------------------------------------------------------------
// qwt_pkg - shared types and constants of the quoted word tokenizer
// Result word layout, queue entry layout and result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qwt_pkg;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // queue between the scanner and the output side
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic [6:0] word_number;
    logic [7:0] word_count;
    logic       limit_hit;
    logic       was_quoted;
  } result_t;

  // one queue entry holds the one or two result words that a scanned byte leaves
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

`default_nettype wire

FILE: sv/qwt_front.sv
// ----------------------------------------------------------------------------
// qwt_front - byte scanner
// Classifies each accepted byte, tracks word and escape state, and builds
// the queue entry holding the result words that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module qwt_front import qwt_pkg::*; #(
  parameter int MAX_WORDS = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] char_in,
  input  wire logic       line_end,
  input  wire logic [7:0] word_limit,
  output push_t           push
);

  localparam logic [1:0] SCAN_OUT    = 2'd0;
  localparam logic [1:0] SCAN_PLAIN  = 2'd1;
  localparam logic [1:0] SCAN_QUOTED = 2'd2;

  localparam logic [1:0] ESC_NONE  = 2'd0;
  localparam logic [1:0] ESC_BSL   = 2'd1;
  localparam logic [1:0] ESC_CARET = 2'd2;

  localparam logic [7:0] MaxWords = 8'(MAX_WORDS);

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSL    = 8'h5c;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  logic [1:0] scan_r, scan_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic       single_r, single_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic       stopped_r, stopped_nxt;

  logic [7:0] lim;
  logic [6:0] cur;
  logic       blank;
  logic       emit;
  entry_t     ent;

  function automatic result_t mk_res(logic [1:0] k, logic [7:0] c, logic [6:0] wn,
                                     logic [7:0] cnt, logic hit, logic q);
    result_t r;
    r.kind        = k;
    r.char_out    = c;
    r.word_number = wn;
    r.word_count  = cnt;
    r.limit_hit   = hit;
    r.was_quoted  = q;
    return r;
  endfunction

  function automatic logic [7:0] bsl_map(logic [7:0] c);
    logic [7:0] v;
    case (c)
      8'h6e:   v = 8'd10; // n
      8'h74:   v = 8'd9;  // t
      8'h72:   v = 8'd13; // r
      8'h66:   v = 8'd12; // f
      8'h62:   v = 8'd8;  // b
      default: v = c;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] caret_map(logic [7:0] c);
    logic [7:0] v;
    if (c == CH_QMARK) begin
      v = CH_DEL;
    end else if (c[7:5] == 3'b010) begin
      v = {3'b000, c[4:0]};
    end else begin
      v = c;
    end
    return v;
  endfunction

  assign lim   = (word_limit > MaxWords) ? MaxWords : word_limit;
  assign cur   = 7'(seen_r - 8'd1);
  assign blank = (char_in == 8'd32) || ((char_in >= 8'd9) && (char_in <= 8'd13));

  always_comb begin
    scan_nxt    = scan_r;
    esc_nxt     = esc_r;
    single_nxt  = single_r;
    seen_nxt    = seen_r;
    stopped_nxt = stopped_r;
    emit        = 1'b0;
    ent         = '0;
    if (line_end) begin
      emit = 1'b1;
      if (scan_r != SCAN_OUT) begin
        ent.two    = 1'b1;
        ent.first  = mk_res(KIND_END, 8'd0, cur, 8'd0, 1'b0, scan_r == SCAN_QUOTED);
        ent.second = mk_res(KIND_SUMMARY, 8'd0, 7'd0, seen_r, stopped_r, 1'b0);
      end else begin
        ent.first  = mk_res(KIND_SUMMARY, 8'd0, 7'd0, seen_r, stopped_r, 1'b0);
      end
      scan_nxt    = SCAN_OUT;
      esc_nxt     = ESC_NONE;
      single_nxt  = 1'b0;
      seen_nxt    = 8'd0;
      stopped_nxt = 1'b0;
    end else if (!stopped_r) begin
      unique case (scan_r)
        SCAN_PLAIN: begin
          emit = 1'b1;
          if (blank) begin
            ent.first = mk_res(KIND_END, 8'd0, cur, 8'd0, 1'b0, 1'b0);
            scan_nxt  = SCAN_OUT;
          end else begin
            ent.first = mk_res(KIND_BYTE, char_in, cur, 8'd0, 1'b0, 1'b0);
          end
        end
        SCAN_QUOTED: begin
          if (esc_r == ESC_BSL) begin
            emit      = 1'b1;
            esc_nxt   = ESC_NONE;
            ent.first = mk_res(KIND_BYTE, bsl_map(char_in), cur, 8'd0, 1'b0, 1'b1);
          end else if (esc_r == ESC_CARET) begin
            emit      = 1'b1;
            esc_nxt   = ESC_NONE;
            ent.first = mk_res(KIND_BYTE, caret_map(char_in), cur, 8'd0, 1'b0, 1'b1);
          end else if (char_in == (single_r ? CH_SQUOTE : CH_DQUOTE)) begin
            emit      = 1'b1;
            scan_nxt  = SCAN_OUT;
            esc_nxt   = ESC_NONE;
            ent.first = mk_res(KIND_END, 8'd0, cur, 8'd0, 1'b0, 1'b1);
          end else if (char_in == CH_BSL) begin
            esc_nxt = ESC_BSL;
          end else if (char_in == CH_CARET) begin
            esc_nxt = ESC_CARET;
          end else begin
            emit      = 1'b1;
            esc_nxt   = ESC_NONE;
            ent.first = mk_res(KIND_BYTE, char_in, cur, 8'd0, 1'b0, 1'b1);
          end
        end
        default: begin
          if (!blank) begin
            if (seen_r >= lim) begin
              stopped_nxt = 1'b1;
            end else begin
              seen_nxt = seen_r + 8'd1;
              if ((char_in == CH_DQUOTE) || (char_in == CH_SQUOTE)) begin
                scan_nxt   = SCAN_QUOTED;
                esc_nxt    = ESC_NONE;
                single_nxt = (char_in == CH_SQUOTE);
              end else begin
                scan_nxt  = SCAN_PLAIN;
                emit      = 1'b1;
                ent.first = mk_res(KIND_BYTE, char_in, 7'(seen_r), 8'd0, 1'b0, 1'b0);
              end
            end
          end
        end
      endcase
    end
  end

  assign push = {fire && emit, ent};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r    <= SCAN_OUT;
      esc_r     <= ESC_NONE;
      single_r  <= 1'b0;
      seen_r    <= 8'd0;
      stopped_r <= 1'b0;
    end else if (fire) begin
      scan_r    <= scan_nxt;
      esc_r     <= esc_nxt;
      single_r  <= single_nxt;
      seen_r    <= seen_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/qwt_queue.sv
// ----------------------------------------------------------------------------
// qwt_queue - short entry queue
// Holds scanned entries so the scanner and the output side stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module qwt_queue import qwt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output entry_t     head
);

  entry_t                 slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_r, rd_r;
  logic [QUEUE_AW:0]      cnt_r;

  assign full  = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push.push) begin
      slot_r[wr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({push.push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/qwt_back.sv
// ----------------------------------------------------------------------------
// qwt_back - result sender
// Sends the head's one or two result words, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module qwt_back import qwt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   empty,
  input  wire entry_t head,
  input  wire logic   out_stall,
  output logic        out_valid,
  output result_t     res,
  output logic        last,
  output logic        pop
);

  logic sub_r, sub_nxt;
  logic fire;

  assign out_valid = !empty;
  assign fire      = out_valid && !out_stall;
  assign res       = sub_r ? head.second : head.first;
  assign last      = sub_r || !head.two;
  assign pop       = fire && last;

  always_comb begin
    sub_nxt = sub_r;
    if (fire) begin
      sub_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/quoted_word_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_unit - quoted word tokenizer top level
// Splits a byte line into words, expands escapes in quoted words, and
// reports the word count at the end of each line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one line byte per word, or a
//   line end mark with in_line_end high. A word is taken at a rising edge
//   with in_valid high and in_stall low.
//   Result channel (out_valid / out_stall): word bytes, end-of-word marks
//   and a line summary; out_last_of_run flags the final result of a byte.
//   Configuration: APB-style port, word_limit at byte address 0.
// Timing:
//   The scanner takes one byte per cycle while in_stall is low; each
//   result goes into the queue when its byte is taken. Most bytes give at
//   most one result; a line end inside a word gives two, sent one after
//   the other, so the rate is set by the single-result-per-cycle output
//   port. A four-entry queue sits between scanner and sender: in_stall
//   rises only when it is full, so a stalled receiver holds the queue and
//   the scanner keeps taking bytes until the queue fills.
// Reset: synchronous, active low; clears line state and queue, and sets
// word_limit to 128.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_word_tokenizer_unit import qwt_pkg::*; #(
  parameter int MAX_WORDS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        in_line_end,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_char_out,
  output logic [6:0]       out_word_number,
  output logic [7:0]       out_word_count,
  output logic             out_limit_hit,
  output logic             out_was_quoted,
  output logic             out_last_of_run,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] limit_r;
  logic       cfg_wr;
  logic       in_fire;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  push_t      q_push;
  entry_t     q_head;
  result_t    res;

  // Register file: only word_limit, at the lower word address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 8'd128;
    end else if (cfg_wr) begin
      limit_r <= pwdata[7:0];
    end
  end

  // Hold off the sender only when the queue has no room.
  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  qwt_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .char_in    (in_char_in),
    .line_end   (in_line_end),
    .word_limit (limit_r),
    .push       (q_push)
  );

  qwt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  qwt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (q_head),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res       (res),
    .last      (out_last_of_run),
    .pop       (q_pop)
  );

  assign out_kind        = res.kind;
  assign out_char_out    = res.char_out;
  assign out_word_number = res.word_number;
  assign out_word_count  = res.word_count;
  assign out_limit_hit   = res.limit_hit;
  assign out_was_quoted  = res.was_quoted;

endmodule

`default_nettype wire
